### src/cwpm_pkg.sv
// ----------------------------------------------------------------------------
// cwpm_pkg
// Shared constants, types and helpers for the convolution window port mapper.
// ----------------------------------------------------------------------------
`default_nettype none

package cwpm_pkg;

    localparam int NUM_MULT    = 64;
    localparam int SLOT_W      = 6;
    localparam int SLOT_CNT_W  = 7;
    localparam int ADDR_W      = 12;
    localparam int MAX_WINDOWS = 16;
    localparam int WIN_W       = 5;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [SLOT_CNT_W-1:0] NUM_MULT_CNT = SLOT_CNT_W'(NUM_MULT);
    localparam logic [WIN_W-1:0]      MAX_WIN_CNT  = WIN_W'(MAX_WINDOWS);

    // result status codes
    localparam logic [2:0] STAT_MAPPED     = 3'd0;
    localparam logic [2:0] STAT_BUSY       = 3'd1;
    localparam logic [2:0] STAT_INPUT_WAIT = 3'd2;
    localparam logic [2:0] STAT_KERN_WAIT  = 3'd3;
    localparam logic [2:0] STAT_NO_ROOM    = 3'd4;
    localparam logic [2:0] STAT_LAYER_END  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_MAP_WIDTH    = 3'd0;
    localparam logic [2:0] CFG_KERNEL_WIDTH = 3'd1;
    localparam logic [2:0] CFG_PAD_AMOUNT   = 3'd2;
    localparam logic [2:0] CFG_PAD_ENABLE   = 3'd3;
    localparam logic [2:0] CFG_IN_MAP       = 3'd4;
    localparam logic [2:0] CFG_OUT_MAP      = 3'd5;
    localparam logic [2:0] CFG_OUT_PER_IN   = 3'd6;

    // one queued job: a whole kernel window or a single status result
    typedef struct packed {
        logic              is_status;
        logic [2:0]        status;
        logic              last;
        logic              lend;
        logic [WIN_W-1:0]  win;
        logic [SLOT_W-1:0] slot;
        logic [ADDR_W-1:0] addr;
        logic [3:0]        zlx;   // kx below this is padding
        logic [3:0]        zrx;   // kx at or above this is padding
        logic [3:0]        zuy;
        logic [3:0]        zdy;
    } win_entry_t;

    function automatic logic [8:0] clamp_width(input logic [8:0] w);
        logic [8:0] r;
        if (w == 9'd0) begin
            r = 9'd1;
        end else if (w > 9'd256) begin
            r = 9'd256;
        end else begin
            r = w;
        end
        return r;
    endfunction

    function automatic logic [3:0] clamp_kernel(input logic [3:0] k);
        logic [3:0] r;
        if (k == 4'd0) begin
            r = 4'd1;
        end else if (k > 4'd8) begin
            r = 4'd8;
        end else begin
            r = k;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

### src/cwpm_queue.sv
// ----------------------------------------------------------------------------
// cwpm_queue
// Short window job queue between the classifier and the slot expander.
// ----------------------------------------------------------------------------
`default_nettype none

module cwpm_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  cwpm_pkg::win_entry_t push_data,
    output logic                 full,
    input  logic                 pop,
    output logic                 valid,
    output cwpm_pkg::win_entry_t pop_data
);
    import cwpm_pkg::*;

    win_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push && !full) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop && valid) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if ((push && !full) && !(pop && valid)) begin
            count_next = count_reg + 1'b1;
        end else if (!(push && !full) && (pop && valid)) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

### src/cwpm_front.sv
// ----------------------------------------------------------------------------
// cwpm_front
// Takes requests, runs the readiness checks window by window, keeps the
// output position and queues window jobs or status results.
// ----------------------------------------------------------------------------
`default_nettype none

module cwpm_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 req_busy,
    input  logic [15:0]          req_fill,
    input  logic [19:0]          req_kfill,
    input  logic [8:0]           w_eff,
    input  logic [3:0]           kw_eff,
    input  logic [2:0]           pad_amount,
    input  logic                 pad_enable,
    input  logic [9:0]           in_map,
    input  logic [9:0]           out_map,
    input  logic [10:0]          out_per_in,
    input  logic                 cfg_wr,
    output logic                 q_push,
    output cwpm_pkg::win_entry_t q_data,
    input  logic                 q_full
);
    import cwpm_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_SETUP1 = 4'd1;
    localparam logic [3:0] S_SETUP2 = 4'd2;
    localparam logic [3:0] S_SETUP3 = 4'd3;
    localparam logic [3:0] S_CHECK0 = 4'd4;
    localparam logic [3:0] S_CHECK1 = 4'd5;
    localparam logic [3:0] S_EVAL   = 4'd6;
    localparam logic [3:0] S_FLUSH  = 4'd7;

    logic [3:0]             state_reg, state_next;
    logic [15:0]            fill_reg, fill_next;
    logic [19:0]            kfill_reg, kfill_next;
    logic [16:0]            ww_reg, ww_next;
    logic [20:0]            ab_reg, ab_next;
    logic [6:0]             kk_reg, kk_next;
    logic [ADDR_W-1:0]      base_reg, base_next;
    logic [21:0]            sbsum_reg, sbsum_next;
    logic [28:0]            sbneed_reg, sbneed_next;
    logic [7:0]             pos_x_reg, pos_x_next;
    logic [7:0]             pos_y_reg, pos_y_next;
    logic                   layer_done_reg, layer_done_next;
    logic signed [10:0]     ty_reg, ty_next, tx_reg, tx_next;
    logic signed [10:0]     sy_reg, sy_next, sx_reg, sx_next;
    logic [3:0]             zlx_reg, zlx_next, zrx_reg, zrx_next;
    logic [3:0]             zuy_reg, zuy_next, zdy_reg, zdy_next;
    logic signed [20:0]     need_reg, need_next;
    logic signed [20:0]     soff_reg, soff_next;
    logic [SLOT_CNT_W-1:0]  k_reg, k_next;
    logic [WIN_W-1:0]       win_reg, win_next;
    win_entry_t             pend_reg, pend_next;
    logic                   pend_valid_reg, pend_valid_next;

    // check-stage arithmetic
    logic signed [10:0] cxs, cys, ws, ps, kws, wm1;
    logic signed [10:0] mx, my, txr, tyr, kmx, kmy;
    logic               zl, zr, zu, zd;
    logic signed [20:0] ty_x, tx_x, sy_x, sx_x, w_x;
    logic [17:0]        ww_full;
    logic [16:0]        base_full;
    logic [2:0]         fail;
    logic [8:0]         cx1, cy1;
    logic [SLOT_CNT_W-1:0] k_sum;
    logic [WIN_W-1:0]   win_inc;
    win_entry_t         new_ent;
    logic               accept;

    assign req_ready = (state_reg == S_IDLE) && !q_full;
    assign accept    = req_valid && req_ready;

    always_comb begin
        cxs = $signed({3'b000, pos_x_reg});
        cys = $signed({3'b000, pos_y_reg});
        ws  = $signed({2'b00, w_eff});
        ps  = $signed({8'b0, pad_amount});
        kws = $signed({7'b0, kw_eff});
        wm1 = ws - 11'sd1;

        zl = (cxs < ps);
        zr = !zl && (cxs >= ws - ps);
        zu = (cys < ps);
        zd = !zu && (cys >= ws - ps);
        mx = zl ? (ps - cxs) : (zr ? (cxs - ws + ps + 11'sd1) : 11'sd0);
        my = zu ? (ps - cys) : (zd ? (cys - ws + ps + 11'sd1) : 11'sd0);
        txr = cxs + kws - mx;
        tyr = cys + kws - my;
        kmx = kws - mx;
        kmy = kws - my;

        ty_x = 21'(ty_reg);
        tx_x = 21'(tx_reg);
        sy_x = 21'(sy_reg);
        sx_x = 21'(sx_reg);
        w_x  = $signed({12'b0, w_eff});

        ww_full   = {9'b0, w_eff} * {9'b0, w_eff};
        base_full = {7'b0, in_map} * ww_reg;

        cx1 = {1'b0, pos_x_reg} + 9'd1;
        cy1 = {1'b0, pos_y_reg} + 9'd1;

        k_sum   = k_reg + kk_reg;
        win_inc = win_reg + 1'b1;

        if (need_reg > $signed({5'b0, fill_reg})) begin
            fail = STAT_INPUT_WAIT;
        end else if (pad_enable && (sbneed_reg > {9'b0, kfill_reg})) begin
            fail = STAT_KERN_WAIT;
        end else if (kk_reg > (NUM_MULT_CNT - k_reg)) begin
            fail = STAT_NO_ROOM;
        end else begin
            fail = STAT_MAPPED;
        end

        new_ent           = '0;
        new_ent.status    = STAT_MAPPED;
        new_ent.win       = win_inc;
        new_ent.slot      = k_reg[SLOT_W-1:0];
        new_ent.addr      = base_reg + soff_reg[ADDR_W-1:0];
        new_ent.zlx       = zlx_reg;
        new_ent.zrx       = zrx_reg;
        new_ent.zuy       = zuy_reg;
        new_ent.zdy       = zdy_reg;
    end

    always_comb begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        kfill_next      = kfill_reg;
        ww_next         = ww_reg;
        ab_next         = ab_reg;
        kk_next         = kk_reg;
        base_next       = base_reg;
        sbsum_next      = sbsum_reg;
        sbneed_next     = sbneed_reg;
        pos_x_next      = pos_x_reg;
        pos_y_next      = pos_y_reg;
        layer_done_next = layer_done_reg;
        ty_next         = ty_reg;
        tx_next         = tx_reg;
        sy_next         = sy_reg;
        sx_next         = sx_reg;
        zlx_next        = zlx_reg;
        zrx_next        = zrx_reg;
        zuy_next        = zuy_reg;
        zdy_next        = zdy_reg;
        need_next       = need_reg;
        soff_next       = soff_reg;
        k_next          = k_reg;
        win_next        = win_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        q_push          = 1'b0;
        q_data          = '0;
        q_data.is_status = 1'b1;
        q_data.last      = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    fill_next       = req_fill;
                    kfill_next      = req_kfill;
                    k_next          = '0;
                    win_next        = '0;
                    pend_valid_next = 1'b0;
                    if (req_busy) begin
                        q_push        = 1'b1;
                        q_data.status = STAT_BUSY;
                    end else if (layer_done_reg) begin
                        q_push        = 1'b1;
                        q_data.status = STAT_LAYER_END;
                    end else begin
                        state_next = S_SETUP1;
                    end
                end
            end
            S_SETUP1: begin
                ww_next    = ww_full[16:0];
                ab_next    = {11'b0, in_map} * {10'b0, out_per_in};
                kk_next    = {3'b000, kw_eff} * {3'b000, kw_eff};
                state_next = S_SETUP2;
            end
            S_SETUP2: begin
                base_next  = base_full[ADDR_W-1:0];
                sbsum_next = {1'b0, ab_reg} + {12'b0, out_map} + 22'd1;
                state_next = S_SETUP3;
            end
            S_SETUP3: begin
                sbneed_next = {7'b0, sbsum_reg} * {22'b0, kk_reg};
                state_next  = S_CHECK0;
            end
            S_CHECK0: begin
                if (pad_enable) begin
                    ty_next  = (tyr < wm1) ? tyr : wm1;
                    tx_next  = (txr < wm1) ? txr : wm1;
                    sy_next  = cys - ps;
                    sx_next  = cxs - ps;
                    zlx_next = zl ? ((mx > 11'sd8) ? 4'd8 : mx[3:0]) : 4'd0;
                    zuy_next = zu ? ((my > 11'sd8) ? 4'd8 : my[3:0]) : 4'd0;
                    zrx_next = zr ? ((kmx <= 11'sd0) ? 4'd0 : kmx[3:0]) : 4'd8;
                    zdy_next = zd ? ((kmy <= 11'sd0) ? 4'd0 : kmy[3:0]) : 4'd8;
                end else begin
                    ty_next  = cys + kws;
                    tx_next  = cxs + kws;
                    sy_next  = cys;
                    sx_next  = cxs;
                    zlx_next = 4'd0;
                    zuy_next = 4'd0;
                    zrx_next = 4'd8;
                    zdy_next = 4'd8;
                end
                state_next = S_CHECK1;
            end
            S_CHECK1: begin
                need_next  = 21'(ty_x * w_x) + tx_x;
                soff_next  = 21'(sy_x * w_x) + sx_x;
                state_next = S_EVAL;
            end
            S_EVAL: begin
                if (fail != STAT_MAPPED) begin
                    if (!pend_valid_reg) begin
                        if (!q_full) begin
                            q_push        = 1'b1;
                            q_data.status = fail;
                            state_next    = S_IDLE;
                        end
                    end else begin
                        state_next = S_FLUSH;
                    end
                end else if (!(pend_valid_reg && q_full)) begin
                    if (pend_valid_reg) begin
                        q_push = 1'b1;
                        q_data = pend_reg;
                    end
                    pend_next       = new_ent;
                    pend_valid_next = 1'b1;
                    k_next          = k_sum;
                    win_next        = win_inc;
                    if (cx1 >= w_eff) begin
                        pos_x_next = '0;
                        if (cy1 >= w_eff) begin
                            pos_y_next      = '0;
                            layer_done_next = 1'b1;
                            pend_next.lend  = 1'b1;
                        end else begin
                            pos_y_next = cy1[7:0];
                        end
                    end else begin
                        pos_x_next = cx1[7:0];
                    end
                    if (((cx1 >= w_eff) && (cy1 >= w_eff)) || (win_inc >= MAX_WIN_CNT)
                        || (k_sum >= NUM_MULT_CNT)) begin
                        state_next = S_FLUSH;
                    end else begin
                        state_next = S_CHECK0;
                    end
                end
            end
            S_FLUSH: begin
                if (!q_full) begin
                    q_push          = 1'b1;
                    q_data          = pend_reg;
                    q_data.last     = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (cfg_wr) begin
            layer_done_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            pos_x_reg      <= '0;
            pos_y_reg      <= '0;
            layer_done_reg <= 1'b0;
            pend_valid_reg <= 1'b0;
            k_reg          <= '0;
            win_reg        <= '0;
        end else begin
            state_reg      <= state_next;
            pos_x_reg      <= pos_x_next;
            pos_y_reg      <= pos_y_next;
            layer_done_reg <= layer_done_next;
            pend_valid_reg <= pend_valid_next;
            k_reg          <= k_next;
            win_reg        <= win_next;
        end
    end

    always_ff @(posedge aclk) begin
        fill_reg   <= fill_next;
        kfill_reg  <= kfill_next;
        ww_reg     <= ww_next;
        ab_reg     <= ab_next;
        kk_reg     <= kk_next;
        base_reg   <= base_next;
        sbsum_reg  <= sbsum_next;
        sbneed_reg <= sbneed_next;
        ty_reg     <= ty_next;
        tx_reg     <= tx_next;
        sy_reg     <= sy_next;
        sx_reg     <= sx_next;
        zlx_reg    <= zlx_next;
        zrx_reg    <= zrx_next;
        zuy_reg    <= zuy_next;
        zdy_reg    <= zdy_next;
        need_reg   <= need_next;
        soff_reg   <= soff_next;
        pend_reg   <= pend_next;
    end

endmodule

`default_nettype wire

### src/cwpm_back.sv
// ----------------------------------------------------------------------------
// cwpm_back
// Expands queued window jobs into one slot result per cycle, while out_ready
// does not stall the output register, and passes status jobs on as one result.
// ----------------------------------------------------------------------------
`default_nettype none

module cwpm_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 q_valid,
    input  cwpm_pkg::win_entry_t q_data,
    output logic                 q_pop,
    input  logic [8:0]           w_eff,
    input  logic [3:0]           kw_eff,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [2:0]           out_status,
    output logic [31:0]          out_data,
    output logic                 out_last
);
    import cwpm_pkg::*;

    logic              act_reg, act_next;
    win_entry_t        ent_reg, ent_next;
    logic [2:0]        kx_reg, kx_next, ky_reg, ky_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic [ADDR_W-1:0] addr_reg, addr_next, row_reg, row_next;
    logic              ov_reg, ov_next;
    logic [2:0]        ost_reg, ost_next;
    logic [31:0]       od_reg, od_next;
    logic              olast_reg, olast_next;

    logic [2:0]        kmax;
    logic              advance, fin, zero, lastres;
    logic [ADDR_W-1:0] w_step;

    assign kmax    = 3'(kw_eff - 4'd1);
    assign w_step  = {3'b000, w_eff};
    assign advance = !ov_reg || out_ready;
    assign fin     = ent_reg.is_status || ((kx_reg == kmax) && (ky_reg == kmax));
    assign q_pop   = q_valid && (!act_reg || (advance && fin));
    assign zero    = ({1'b0, kx_reg} < ent_reg.zlx) || ({1'b0, kx_reg} >= ent_reg.zrx)
                  || ({1'b0, ky_reg} < ent_reg.zuy) || ({1'b0, ky_reg} >= ent_reg.zdy);
    assign lastres = ent_reg.last && fin;

    assign out_valid  = ov_reg;
    assign out_status = ost_reg;
    assign out_data   = od_reg;
    assign out_last   = olast_reg;

    always_comb begin
        act_next   = act_reg;
        ent_next   = ent_reg;
        kx_next    = kx_reg;
        ky_next    = ky_reg;
        slot_next  = slot_reg;
        addr_next  = addr_reg;
        row_next   = row_reg;
        ov_next    = ov_reg;
        ost_next   = ost_reg;
        od_next    = od_reg;
        olast_next = olast_reg;

        if (advance) begin
            ov_next = act_reg;
        end

        if (act_reg && advance) begin
            if (ent_reg.is_status) begin
                ost_next   = ent_reg.status;
                od_next    = '0;
                olast_next = 1'b1;
            end else begin
                ost_next   = ent_reg.status;
                od_next    = {7'b0, ent_reg.lend && lastres, ent_reg.win,
                              zero ? {ADDR_W{1'b0}} : addr_reg, zero, slot_reg};
                olast_next = lastres;
            end
            slot_next = slot_reg + 1'b1;
            if (kx_reg == kmax) begin
                kx_next   = '0;
                ky_next   = ky_reg + 1'b1;
                row_next  = row_reg + w_step;
                addr_next = row_reg + w_step;
            end else begin
                kx_next   = kx_reg + 1'b1;
                addr_next = addr_reg + 1'b1;
            end
            if (fin) begin
                act_next = 1'b0;
            end
        end

        if (q_pop) begin
            act_next  = 1'b1;
            ent_next  = q_data;
            kx_next   = '0;
            ky_next   = '0;
            slot_next = q_data.slot;
            addr_next = q_data.addr;
            row_next  = q_data.addr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_reg <= 1'b0;
            ov_reg  <= 1'b0;
        end else begin
            act_reg <= act_next;
            ov_reg  <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg   <= ent_next;
        kx_reg    <= kx_next;
        ky_reg    <= ky_next;
        slot_reg  <= slot_next;
        addr_reg  <= addr_next;
        row_reg   <= row_next;
        ost_reg   <= ost_next;
        od_reg    <= od_next;
        olast_reg <= olast_next;
    end

endmodule

`default_nettype wire

### src/conv_window_port_mapper_core.sv
// ----------------------------------------------------------------------------
// conv_window_port_mapper_core
// Maps whole kernel windows onto multiplier slots, one result per slot.
// ----------------------------------------------------------------------------
// channel   direction  handshake             payload
// s_*       in         s_tvalid / s_tready   request: busy flag, fill levels
// m_*       out        m_tvalid / m_tready   slot result, status in tuser
// cfg_*     in         cfg_valid / cfg_ready register index and value
//
// Classifier: set-up states SETUP1 to SETUP3 per request, then CHECK0, CHECK1 and
// EVAL per window check, and FLUSH to hand over the last window. Expander: one
// transfer per cycle while m_tready is high, k*k per window. A busy or layer-ended
// request is answered with a single status result straight from the idle state.
// Reset clears the position, the layer-ended flag and the queue and loads
// the register defaults; a four-job queue absorbs m_tready stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module conv_window_port_mapper_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // mult_busy, input_fill, kernel_fill
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // slot, use_zero, address, windows_done, layer_end
    output logic [2:0]  m_tuser,   // status
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [10:0] cfg_data
);
    import cwpm_pkg::*;

    logic [8:0]  map_width_reg;
    logic [3:0]  kernel_width_reg;
    logic [2:0]  pad_amount_reg;
    logic        pad_enable_reg;
    logic [9:0]  in_map_reg;
    logic [9:0]  out_map_reg;
    logic [10:0] out_per_in_reg;

    logic        cfg_wr;
    logic [8:0]  w_eff;
    logic [3:0]  kw_eff;
    logic        q_push, q_full, q_pop, q_valid;
    win_entry_t  q_in, q_out;

    assign cfg_ready = 1'b1;
    assign w_eff     = clamp_width(map_width_reg);
    assign kw_eff    = clamp_kernel(kernel_width_reg);

    always_comb begin
        case (cfg_index)
            CFG_MAP_WIDTH, CFG_KERNEL_WIDTH, CFG_PAD_AMOUNT, CFG_PAD_ENABLE,
            CFG_IN_MAP, CFG_OUT_MAP, CFG_OUT_PER_IN: begin
                cfg_wr = cfg_valid;
            end
            default: begin
                cfg_wr = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg    <= 9'd8;
            kernel_width_reg <= 4'd3;
            pad_amount_reg   <= 3'd1;
            pad_enable_reg   <= 1'b0;
            in_map_reg       <= '0;
            out_map_reg      <= '0;
            out_per_in_reg   <= 11'd1;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_MAP_WIDTH:    map_width_reg    <= cfg_data[8:0];
                CFG_KERNEL_WIDTH: kernel_width_reg <= cfg_data[3:0];
                CFG_PAD_AMOUNT:   pad_amount_reg   <= cfg_data[2:0];
                CFG_PAD_ENABLE:   pad_enable_reg   <= cfg_data[0];
                CFG_IN_MAP:       in_map_reg       <= cfg_data[9:0];
                CFG_OUT_MAP:      out_map_reg      <= cfg_data[9:0];
                CFG_OUT_PER_IN:   out_per_in_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    cwpm_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req_busy   (s_tdata[0]),
        .req_fill   (s_tdata[16:1]),
        .req_kfill  (s_tdata[36:17]),
        .w_eff      (w_eff),
        .kw_eff     (kw_eff),
        .pad_amount (pad_amount_reg),
        .pad_enable (pad_enable_reg),
        .in_map     (in_map_reg),
        .out_map    (out_map_reg),
        .out_per_in (out_per_in_reg),
        .cfg_wr     (cfg_wr),
        .q_push     (q_push),
        .q_data     (q_in),
        .q_full     (q_full)
    );

    cwpm_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .valid     (q_valid),
        .pop_data  (q_out)
    );

    cwpm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_valid    (q_valid),
        .q_data     (q_out),
        .q_pop      (q_pop),
        .w_eff      (w_eff),
        .kw_eff     (kw_eff),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_data   (m_tdata),
        .out_last   (m_tlast)
    );

endmodule

`default_nettype wire
